// ----- hdl/ttdq_pkg.sv -----
`default_nettype none
package ttdq_pkg;

  localparam int SLOTS       = 16;
  localparam int SLOT_W      = $clog2(SLOTS);
  localparam int TIME_W      = 32;
  localparam int LEN_W       = $clog2(SLOTS + 1);
  localparam int MAX_RESULTS = 16;
  localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [2:0] {
    MODE_TICK     = 3'd0,
    MODE_RUN      = 3'd1,
    MODE_ADD_PER  = 3'd2,
    MODE_ADD_ONE  = 3'd3,
    MODE_REMOVE   = 3'd4,
    MODE_SUSPEND  = 3'd5,
    MODE_RESUME   = 3'd6,
    MODE_CHANGE   = 3'd7
  } mode_t;

  typedef enum logic [2:0] {
    KIND_DONE     = 3'd0,
    KIND_ADDED    = 3'd1,
    KIND_FAIL     = 3'd2,
    KIND_DISPATCH = 3'd3,
    KIND_NONE     = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CMD,
    ST_IV,
    ST_RM_RD,
    ST_RM_EV,
    ST_INS_GO,
    ST_INS_RD,
    ST_INS_EV,
    ST_RUN_CHK,
    ST_RUN_EV,
    ST_RUN_PUSH,
    ST_RUN_NEXT,
    ST_RUN_END,
    ST_FIN
  } state_t;

  typedef enum logic [1:0] {
    RMC_DONE,
    RMC_INS,
    RMC_RUN
  } rmc_t;

  typedef struct packed {
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] due;
  } qent_t;

  typedef struct packed {
    logic              valid;
    kind_t             kind;
    logic [SLOT_W-1:0] slot;
    logic              last;
  } push_t;

endpackage
`default_nettype wire

// ----- hdl/timed_task_dispatch_queue_core.sv -----
`default_nettype none
// Timed task dispatch queue. Up to 16 task slots are kept, and the queued slots
// sit in a memory sorted by due time, ties in insertion order. A tick, a failed
// add or a command on an inactive slot goes from the command state straight to
// the result state. Commands that touch the queue walk it one entry at a time
// (the queue memory has one registered read port). Remove and suspend walk the
// queue once to unlink the slot, and an add walks it from the tail to insert
// the slot. Resume and change walk the queue twice, once to unlink the slot and
// once to insert it again. A run drops the head and reinserts a periodic slot
// for every dispatch, up to 16 dispatches per run. A new beat is taken only
// while the block is idle. Results leave through a one-beat output register,
// and the block holds its final result until that register has room, so a
// stalled receiver stops the next command once one result beat is waiting.
module timed_task_dispatch_queue_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_mode,
  input  wire logic [3:0]  in_task_id,
  input  wire logic [31:0] in_time_value,
  input  wire logic        in_resume_now,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [3:0]       out_slot_id,
  output logic             out_is_last
);

  ttdq_pkg::push_t push;
  logic            push_rdy;
  logic            out_valid_r;
  logic [2:0]      out_kind_r;
  logic [3:0]      out_slot_r;
  logic            out_last_r;

  // The output register may be refilled in the cycle its beat is taken.
  assign push_rdy = !out_valid_r || out_ready;

  ttdq_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_mode(in_mode), .in_task_id(in_task_id),
    .in_time_value(in_time_value), .in_resume_now(in_resume_now),
    .push(push), .push_rdy(push_rdy)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) begin
      out_kind_r <= push.kind;
      out_slot_r <= push.slot;
      out_last_r <= push.last;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_slot_id = out_slot_r;
  assign out_is_last = out_last_r;

endmodule
`default_nettype wire

// ----- hdl/ttdq_ram.sv -----
`default_nettype none
module ttdq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read enable.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hdl/ttdq_ctrl.sv -----
`default_nettype none
module ttdq_ctrl (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [2:0]                   in_mode,
  input  wire logic [ttdq_pkg::SLOT_W-1:0]  in_task_id,
  input  wire logic [ttdq_pkg::TIME_W-1:0]  in_time_value,
  input  wire logic                         in_resume_now,
  output ttdq_pkg::push_t                   push,
  input  wire logic                         push_rdy
);

  localparam int QW = $bits(ttdq_pkg::qent_t);

  ttdq_pkg::state_t                 state_r, state_nxt;
  ttdq_pkg::mode_t                  op_r, op_nxt;
  logic [ttdq_pkg::SLOT_W-1:0]      id_r, id_nxt;
  logic [ttdq_pkg::TIME_W-1:0]      tv_r, tv_nxt;
  logic                             now_r, now_nxt;
  logic [ttdq_pkg::TIME_W-1:0]      time_r, time_nxt;
  logic [ttdq_pkg::LEN_W-1:0]       len_r, len_nxt;
  logic [ttdq_pkg::SLOTS-1:0]       active_r, active_nxt;
  logic [ttdq_pkg::SLOTS-1:0]       susp_r, susp_nxt;
  logic [ttdq_pkg::LEN_W-1:0]       idx_r, idx_nxt;
  logic                             found_r, found_nxt;
  logic [ttdq_pkg::SLOT_W-1:0]      key_r, key_nxt;
  ttdq_pkg::rmc_t                   rmc_r, rmc_nxt;
  logic                             ins_run_r, ins_run_nxt;
  logic [ttdq_pkg::SLOT_W-1:0]      new_slot_r, new_slot_nxt;
  logic [ttdq_pkg::TIME_W-1:0]      new_due_r, new_due_nxt;
  logic [ttdq_pkg::CNT_W-1:0]       cnt_r, cnt_nxt;
  logic                             pend_v_r, pend_v_nxt;
  logic [ttdq_pkg::SLOT_W-1:0]      pend_slot_r, pend_slot_nxt;
  ttdq_pkg::kind_t                  fin_kind_r, fin_kind_nxt;
  logic [ttdq_pkg::SLOT_W-1:0]      fin_slot_r, fin_slot_nxt;

  logic                             q_we, q_re;
  logic [ttdq_pkg::SLOT_W-1:0]      q_waddr, q_raddr;
  ttdq_pkg::qent_t                  q_wdata, q_rd;
  logic [QW-1:0]                    q_rdata;
  logic                             iv_we, iv_re;
  logic [ttdq_pkg::SLOT_W-1:0]      iv_waddr, iv_raddr;
  logic [ttdq_pkg::TIME_W-1:0]      iv_wdata, iv_rd;

  logic                             free_found;
  logic [ttdq_pkg::SLOT_W-1:0]      free_idx;
  logic                             id_valid;
  logic [ttdq_pkg::TIME_W-1:0]      clamp_tv;
  logic [ttdq_pkg::LEN_W-1:0]       idx_m1;
  ttdq_pkg::qent_t                  new_ent;

  assign q_rd     = ttdq_pkg::qent_t'(q_rdata);
  assign id_valid = active_r[id_r];
  assign clamp_tv = (tv_r == '0) ? ttdq_pkg::TIME_W'(1) : tv_r;
  assign idx_m1   = idx_r - 1'b1;
  assign new_ent  = '{slot: new_slot_r, due: new_due_r};

  ttdq_ram #(.WIDTH(QW), .DEPTH(ttdq_pkg::SLOTS)) u_qram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .re(q_re), .raddr(q_raddr), .rdata(q_rdata)
  );

  ttdq_ram #(.WIDTH(ttdq_pkg::TIME_W), .DEPTH(ttdq_pkg::SLOTS)) u_ivram (
    .clk(clk), .we(iv_we), .waddr(iv_waddr), .wdata(iv_wdata),
    .re(iv_re), .raddr(iv_raddr), .rdata(iv_rd)
  );

  // Lowest inactive slot.
  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = ttdq_pkg::SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = ttdq_pkg::SLOT_W'(i);
      end
    end
  end

  // Next state and datapath updates.
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    tv_nxt        = tv_r;
    now_nxt       = now_r;
    time_nxt      = time_r;
    len_nxt       = len_r;
    active_nxt    = active_r;
    susp_nxt      = susp_r;
    idx_nxt       = idx_r;
    found_nxt     = found_r;
    key_nxt       = key_r;
    rmc_nxt       = rmc_r;
    ins_run_nxt   = ins_run_r;
    new_slot_nxt  = new_slot_r;
    new_due_nxt   = new_due_r;
    cnt_nxt       = cnt_r;
    pend_v_nxt    = pend_v_r;
    pend_slot_nxt = pend_slot_r;
    fin_kind_nxt  = fin_kind_r;
    fin_slot_nxt  = fin_slot_r;

    case (state_r)
      ttdq_pkg::ST_IDLE: begin
        if (in_valid) begin
          op_nxt    = ttdq_pkg::mode_t'(in_mode);
          id_nxt    = in_task_id;
          tv_nxt    = in_time_value;
          now_nxt   = in_resume_now;
          state_nxt = ttdq_pkg::ST_CMD;
        end
      end
      ttdq_pkg::ST_CMD: begin
        fin_kind_nxt = ttdq_pkg::KIND_DONE;
        fin_slot_nxt = '0;
        ins_run_nxt  = 1'b0;
        key_nxt      = id_r;
        found_nxt    = 1'b0;
        idx_nxt      = '0;
        state_nxt    = ttdq_pkg::ST_FIN;
        case (op_r)
          ttdq_pkg::MODE_TICK: begin
            time_nxt = time_r + 1'b1;
          end
          ttdq_pkg::MODE_RUN: begin
            cnt_nxt    = '0;
            pend_v_nxt = 1'b0;
            state_nxt  = ttdq_pkg::ST_RUN_CHK;
          end
          ttdq_pkg::MODE_ADD_PER, ttdq_pkg::MODE_ADD_ONE: begin
            if (!free_found) begin
              fin_kind_nxt = ttdq_pkg::KIND_FAIL;
            end else begin
              active_nxt[free_idx] = 1'b1;
              susp_nxt[free_idx]   = 1'b0;
              fin_kind_nxt         = ttdq_pkg::KIND_ADDED;
              fin_slot_nxt         = free_idx;
              new_slot_nxt         = free_idx;
              new_due_nxt          = time_r + tv_r;
              state_nxt            = ttdq_pkg::ST_INS_GO;
            end
          end
          ttdq_pkg::MODE_REMOVE: begin
            if (id_valid) begin
              active_nxt[id_r] = 1'b0;
              susp_nxt[id_r]   = 1'b0;
              rmc_nxt          = ttdq_pkg::RMC_DONE;
              state_nxt        = ttdq_pkg::ST_RM_RD;
            end
          end
          ttdq_pkg::MODE_SUSPEND: begin
            if (id_valid) begin
              susp_nxt[id_r] = 1'b1;
              rmc_nxt        = ttdq_pkg::RMC_DONE;
              state_nxt      = ttdq_pkg::ST_RM_RD;
            end
          end
          ttdq_pkg::MODE_RESUME: begin
            if (id_valid) begin
              state_nxt = ttdq_pkg::ST_IV;
            end
          end
          default: begin
            if (id_valid) begin
              new_due_nxt    = now_r ? time_r : time_r + clamp_tv;
              new_slot_nxt   = id_r;
              susp_nxt[id_r] = 1'b0;
              rmc_nxt        = ttdq_pkg::RMC_INS;
              state_nxt      = ttdq_pkg::ST_RM_RD;
            end
          end
        endcase
      end
      ttdq_pkg::ST_IV: begin
        new_due_nxt    = now_r ? time_r : time_r + iv_rd;
        new_slot_nxt   = id_r;
        susp_nxt[id_r] = 1'b0;
        rmc_nxt        = ttdq_pkg::RMC_INS;
        state_nxt      = ttdq_pkg::ST_RM_RD;
      end
      ttdq_pkg::ST_RM_RD: begin
        if (idx_r < len_r) begin
          state_nxt = ttdq_pkg::ST_RM_EV;
        end else begin
          if (found_r) begin
            len_nxt = len_r - 1'b1;
          end
          case (rmc_r)
            ttdq_pkg::RMC_INS: state_nxt = ttdq_pkg::ST_INS_GO;
            ttdq_pkg::RMC_RUN: state_nxt = ttdq_pkg::ST_RUN_NEXT;
            default:           state_nxt = ttdq_pkg::ST_FIN;
          endcase
        end
      end
      ttdq_pkg::ST_RM_EV: begin
        if (!found_r && q_rd.slot == key_r) begin
          found_nxt = 1'b1;
        end
        idx_nxt   = idx_r + 1'b1;
        state_nxt = ttdq_pkg::ST_RM_RD;
      end
      ttdq_pkg::ST_INS_GO: begin
        idx_nxt = len_r;
        if (len_r == ttdq_pkg::LEN_W'(ttdq_pkg::SLOTS)) begin
          state_nxt = ins_run_r ? ttdq_pkg::ST_RUN_CHK : ttdq_pkg::ST_FIN;
        end else begin
          state_nxt = ttdq_pkg::ST_INS_RD;
        end
      end
      ttdq_pkg::ST_INS_RD: begin
        if (idx_r == '0) begin
          len_nxt   = len_r + 1'b1;
          state_nxt = ins_run_r ? ttdq_pkg::ST_RUN_CHK : ttdq_pkg::ST_FIN;
        end else begin
          state_nxt = ttdq_pkg::ST_INS_EV;
        end
      end
      ttdq_pkg::ST_INS_EV: begin
        if (q_rd.due > new_due_r) begin
          idx_nxt   = idx_m1;
          state_nxt = ttdq_pkg::ST_INS_RD;
        end else begin
          len_nxt   = len_r + 1'b1;
          state_nxt = ins_run_r ? ttdq_pkg::ST_RUN_CHK : ttdq_pkg::ST_FIN;
        end
      end
      ttdq_pkg::ST_RUN_CHK: begin
        if (cnt_r < ttdq_pkg::CNT_W'(ttdq_pkg::MAX_RESULTS) && len_r != '0) begin
          state_nxt = ttdq_pkg::ST_RUN_EV;
        end else begin
          state_nxt = ttdq_pkg::ST_RUN_END;
        end
      end
      ttdq_pkg::ST_RUN_EV: begin
        if (q_rd.due <= time_r) begin
          new_slot_nxt = q_rd.slot;
          state_nxt    = ttdq_pkg::ST_RUN_PUSH;
        end else begin
          state_nxt = ttdq_pkg::ST_RUN_END;
        end
      end
      ttdq_pkg::ST_RUN_PUSH: begin
        if (!pend_v_r || push_rdy) begin
          pend_v_nxt    = 1'b1;
          pend_slot_nxt = new_slot_r;
          cnt_nxt       = cnt_r + 1'b1;
          found_nxt     = 1'b1;
          idx_nxt       = ttdq_pkg::LEN_W'(1);
          rmc_nxt       = ttdq_pkg::RMC_RUN;
          state_nxt     = ttdq_pkg::ST_RM_RD;
        end
      end
      ttdq_pkg::ST_RUN_NEXT: begin
        if (iv_rd != '0) begin
          new_due_nxt = time_r + iv_rd;
          ins_run_nxt = 1'b1;
          state_nxt   = ttdq_pkg::ST_INS_GO;
        end else begin
          active_nxt[new_slot_r] = 1'b0;
          state_nxt              = ttdq_pkg::ST_RUN_CHK;
        end
      end
      ttdq_pkg::ST_RUN_END: begin
        if (push_rdy) begin
          pend_v_nxt = 1'b0;
          state_nxt  = ttdq_pkg::ST_IDLE;
        end
      end
      ttdq_pkg::ST_FIN: begin
        if (push_rdy) begin
          state_nxt = ttdq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = ttdq_pkg::ST_IDLE;
      end
    endcase
  end

  // Memory ports, handshake and result pushes.
  always_comb begin
    in_ready = (state_r == ttdq_pkg::ST_IDLE);
    q_we     = 1'b0;
    q_waddr  = '0;
    q_wdata  = new_ent;
    q_re     = 1'b0;
    q_raddr  = '0;
    iv_we    = 1'b0;
    iv_waddr = '0;
    iv_wdata = '0;
    iv_re    = 1'b0;
    iv_raddr = '0;
    push     = '{valid: 1'b0, kind: ttdq_pkg::KIND_DONE, slot: '0, last: 1'b0};

    case (state_r)
      ttdq_pkg::ST_CMD: begin
        case (op_r)
          ttdq_pkg::MODE_ADD_PER, ttdq_pkg::MODE_ADD_ONE: begin
            iv_we    = free_found;
            iv_waddr = free_idx;
            iv_wdata = (op_r == ttdq_pkg::MODE_ADD_PER) ? tv_r : '0;
          end
          ttdq_pkg::MODE_RESUME: begin
            iv_re    = id_valid;
            iv_raddr = id_r;
          end
          ttdq_pkg::MODE_CHANGE: begin
            iv_we    = id_valid;
            iv_waddr = id_r;
            iv_wdata = clamp_tv;
          end
          default: begin
          end
        endcase
      end
      ttdq_pkg::ST_RM_RD: begin
        q_re    = (idx_r < len_r);
        q_raddr = idx_r[ttdq_pkg::SLOT_W-1:0];
      end
      ttdq_pkg::ST_RM_EV: begin
        q_we    = found_r;
        q_waddr = idx_m1[ttdq_pkg::SLOT_W-1:0];
        q_wdata = q_rd;
      end
      ttdq_pkg::ST_INS_RD: begin
        if (idx_r == '0) begin
          q_we    = 1'b1;
          q_waddr = '0;
        end else begin
          q_re    = 1'b1;
          q_raddr = idx_m1[ttdq_pkg::SLOT_W-1:0];
        end
      end
      ttdq_pkg::ST_INS_EV: begin
        q_we    = 1'b1;
        q_waddr = idx_r[ttdq_pkg::SLOT_W-1:0];
        q_wdata = (q_rd.due > new_due_r) ? q_rd : new_ent;
      end
      ttdq_pkg::ST_RUN_CHK: begin
        q_re    = (cnt_r < ttdq_pkg::CNT_W'(ttdq_pkg::MAX_RESULTS)) && (len_r != '0);
        q_raddr = '0;
      end
      ttdq_pkg::ST_RUN_EV: begin
        iv_re    = (q_rd.due <= time_r);
        iv_raddr = q_rd.slot;
      end
      ttdq_pkg::ST_RUN_PUSH: begin
        push = '{valid: pend_v_r && push_rdy, kind: ttdq_pkg::KIND_DISPATCH,
                 slot: pend_slot_r, last: 1'b0};
      end
      ttdq_pkg::ST_RUN_END: begin
        if (pend_v_r) begin
          push = '{valid: push_rdy, kind: ttdq_pkg::KIND_DISPATCH,
                   slot: pend_slot_r, last: 1'b1};
        end else begin
          push = '{valid: push_rdy, kind: ttdq_pkg::KIND_NONE, slot: '0, last: 1'b1};
        end
      end
      ttdq_pkg::ST_FIN: begin
        push = '{valid: push_rdy, kind: fin_kind_r, slot: fin_slot_r, last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ttdq_pkg::ST_IDLE;
      time_r   <= '0;
      len_r    <= '0;
      active_r <= '0;
      susp_r   <= '0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      time_r   <= time_nxt;
      len_r    <= len_nxt;
      active_r <= active_nxt;
      susp_r   <= susp_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    id_r        <= id_nxt;
    tv_r        <= tv_nxt;
    now_r       <= now_nxt;
    idx_r       <= idx_nxt;
    found_r     <= found_nxt;
    key_r       <= key_nxt;
    rmc_r       <= rmc_nxt;
    ins_run_r   <= ins_run_nxt;
    new_slot_r  <= new_slot_nxt;
    new_due_r   <= new_due_nxt;
    cnt_r       <= cnt_nxt;
    pend_slot_r <= pend_slot_nxt;
    fin_kind_r  <= fin_kind_nxt;
    fin_slot_r  <= fin_slot_nxt;
  end

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= ttdq_pkg::LEN_W'(ttdq_pkg::SLOTS))
    else $error("queue length above slot count");

  a_susp_active: assert property (@(posedge clk) disable iff (!rst_n)
    (susp_r & ~active_r) == '0)
    else $error("suspended slot is not active");

  a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ttdq_pkg::ST_IDLE |-> !pend_v_r)
    else $error("dispatch left pending at idle");

  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.valid |-> push_rdy)
    else $error("result pushed into a full output register");

endmodule
`default_nettype wire
